// File: rtl/core/auth_attempt_lockout_unit_assert.svh
// assertion macros for the attempt lockout unit
// expects clk and arst_n in the scope where a macro is used
`ifndef AUTH_ATTEMPT_LOCKOUT_UNIT_ASSERT_SVH
`define AUTH_ATTEMPT_LOCKOUT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AAL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define AAL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/aal_pkg.sv
// shared types, codes and constants of the attempt lockout unit
// no dependencies
package aal_pkg;

	// request codes
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_ATTEMPT = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_GUARDED     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_MISSES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAUSE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DBL     = 2'd3;

	// field widths
	localparam int MISS_W = 8;
	localparam int FREE_W = 4;
	localparam int BASE_W = 16;
	localparam int DBL_W  = 3;
	localparam int WAIT_W = 15;
	// widest pause that a load can produce: base shifted by the largest doubling
	localparam int LOAD_W = BASE_W + (1 << DBL_W) - 1;

	// reset values of the configuration registers
	localparam logic              GUARDED_RST     = 1'b0;
	localparam logic [FREE_W-1:0] FREE_MISSES_RST = 4'd5;
	localparam logic [BASE_W-1:0] BASE_PAUSE_RST  = 16'd30000;
	localparam logic [DBL_W-1:0]  MAX_DBL_RST     = 3'd5;

	localparam logic [MISS_W-1:0] MISS_MAX = 8'hFF;
	localparam logic [WAIT_W-1:0] WAIT_MAX = 15'h7FFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic       proof_ok;
	} in_item_t;

	typedef struct packed {
		logic              granted;
		logic [WAIT_W-1:0] wait_seconds;
		logic [MISS_W-1:0] misses_now;
		logic              locked;
	} out_item_t;

	// status of one item, handed from the update stage to the output stage
	typedef struct packed {
		logic              granted;
		logic [MISS_W-1:0] misses_now;
		logic              locked;
	} aal_stat_t;

	// largest value the pause timer can ever hold for a timer of tb bits
	function automatic logic [63:0] pause_bound(input int tb);
		logic [63:0] load_max;
		logic [63:0] timer_max;
		load_max  = (64'd1 << LOAD_W) - 64'd1;
		load_max  = load_max - ((64'd1 << ((1 << DBL_W) - 1)) - 64'd1);
		timer_max = (64'd1 << tb) - 64'd1;
		return (load_max < timer_max) ? load_max : timer_max;
	endfunction

endpackage

// File: rtl/core/auth_attempt_lockout_unit.sv
// attempt lockout unit: items pass stage 1 and then the result register; one item
// per cycle unless out_ready stalls; the miss count and pause timer update in the
// accept cycle, and the seconds conversion multiply fills the second stage.
// arst_n clears the state, the pipeline valids and loads the register defaults.
// depends on aal_pkg, aal_out_stage and auth_attempt_lockout_unit_assert.svh
`include "auth_attempt_lockout_unit_assert.svh"

module auth_attempt_lockout_unit import aal_pkg::*; #(
	parameter int PAUSE_TIMER_BITS = 24,
	parameter int MS_PER_SECOND    = 1000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int          TB        = PAUSE_TIMER_BITS;
	localparam logic [63:0] TIMER_MAX = (64'd1 << TB) - 64'd1;
	localparam logic [63:0] PAUSE_MAX = pause_bound(TB);

	logic              guarded_q;
	logic [FREE_W-1:0] free_misses_q;
	logic [BASE_W-1:0] base_pause_q;
	logic [DBL_W-1:0]  max_dbl_q;

	logic [MISS_W-1:0] miss_q, miss_nxt, miss_inc, shift_raw;
	logic [TB-1:0]     pause_q, pause_nxt, load_pause;
	logic [DBL_W-1:0]  shift_amt;
	logic [LOAD_W-1:0] load_ms;
	logic              grant_nxt;

	logic      valid_s1, granted_s1;
	logic      in_fire, s1_adv;
	aal_stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guarded_q     <= GUARDED_RST;
			free_misses_q <= FREE_MISSES_RST;
			base_pause_q  <= BASE_PAUSE_RST;
			max_dbl_q     <= MAX_DBL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GUARDED:     guarded_q     <= cfg_data[0];
				CFG_FREE_MISSES: free_misses_q <= cfg_data[FREE_W-1:0];
				CFG_BASE_PAUSE:  base_pause_q  <= cfg_data[BASE_W-1:0];
				CFG_MAX_DBL:     max_dbl_q     <= cfg_data[DBL_W-1:0];
				default: ;
			endcase
		end
	end

	// pause length for a miss that reaches the free limit
	always_comb begin
		miss_inc  = (miss_q == MISS_MAX) ? miss_q : miss_q + MISS_W'(1);
		shift_raw = miss_inc - MISS_W'(free_misses_q);
		shift_amt = (shift_raw > MISS_W'(max_dbl_q)) ? max_dbl_q : shift_raw[DBL_W-1:0];
		load_ms   = LOAD_W'(base_pause_q) << shift_amt;
		load_pause = (64'(load_ms) > TIMER_MAX) ? TB'(TIMER_MAX) : TB'(load_ms);
	end

	// next state for the item at the input
	always_comb begin
		miss_nxt  = miss_q;
		pause_nxt = pause_q;
		grant_nxt = 1'b0;
		case (in_item.req_type)
			REQ_TICK: begin
				if (pause_q != '0)
					pause_nxt = pause_q - TB'(1);
			end
			REQ_ATTEMPT: begin
				if (!guarded_q) begin
					grant_nxt = 1'b1;
				end else if (pause_q != '0) begin
					grant_nxt = 1'b0;
				end else if (in_item.proof_ok) begin
					miss_nxt  = '0;
					grant_nxt = 1'b1;
				end else begin
					miss_nxt = miss_inc;
					if (miss_inc >= MISS_W'(free_misses_q))
						pause_nxt = load_pause;
				end
			end
			REQ_CLEAR: begin
				miss_nxt  = '0;
				pause_nxt = '0;
			end
			default: ;
		endcase
	end

	// handshake: stage 1 moves on when the result register is free or drains
	assign s1_adv   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q    <= '0;
			pause_q   <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				miss_q  <= miss_nxt;
				pause_q <= pause_nxt;
			end
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s1_adv)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// grant of the item in stage 1
	always_ff @(posedge clk) begin
		if (in_fire)
			granted_s1 <= grant_nxt;
	end

	// a new item only enters when stage 1 is empty or leaving, so the state registers always
	// hold the state right after the item in stage 1
	assign stat.granted    = granted_s1;
	assign stat.misses_now = miss_q;
	assign stat.locked     = (pause_q != '0);

	aal_out_stage #(
		.PAUSE_BITS    (TB),
		.MS_PER_SECOND (MS_PER_SECOND)
	) u_out (
		.clk    (clk),
		.load   (s1_adv),
		.stat   (stat),
		.pause  (pause_q),
		.item_q (out_item)
	);

	// checks
	`AAL_ASSERT_IMP(a_lock_wait, out_valid, out_item.locked == (out_item.wait_seconds != '0), "locked and wait disagree")
	`AAL_ASSERT_NXT(a_grant_attempt, in_fire && (in_item.req_type != REQ_ATTEMPT), !granted_s1, "grant on a non-attempt item")
	`AAL_ASSERT_NXT(a_clear, in_fire && (in_item.req_type == REQ_CLEAR), (miss_q == '0) && (pause_q == '0), "clear left state behind")
	`AAL_ASSERT_IMP(a_pause_bound, 1'b1, 64'(pause_q) <= PAUSE_MAX, "pause beyond largest load")

endmodule

// File: rtl/core/aal_out_stage.sv
// output register stage: converts the pause to whole seconds, rounded up
// depends on aal_pkg
module aal_out_stage import aal_pkg::*; #(
	parameter int PAUSE_BITS    = 24,
	parameter int MS_PER_SECOND = 1000
) (
	input  logic                  clk,
	input  logic                  load,
	input  aal_stat_t             stat,
	input  logic [PAUSE_BITS-1:0] pause,
	output out_item_t             item_q
);

	// ceil(pause / MS_PER_SECOND) = floor((pause + MS_PER_SECOND - 1) / MS_PER_SECOND),
	// taken as a multiply by a rounded-up reciprocal that is exact over the whole
	// range of the sum
	localparam logic [63:0] PAUSE_MAX = pause_bound(PAUSE_BITS);
	localparam int          YW        = $clog2(PAUSE_MAX + 64'(MS_PER_SECOND));
	localparam int          LW        = $clog2(MS_PER_SECOND);
	localparam int          SHIFT     = YW + LW;
	localparam int          MW        = YW + 1;
	localparam logic [63:0] RECIP     =
		((64'd1 << SHIFT) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND);
	localparam int          PW        = YW + MW;
	localparam int          QW        = PW - SHIFT;

	logic [YW-1:0] sum;
	logic [PW-1:0] prod;
	logic [QW-1:0] quot;
	logic [WAIT_W-1:0] secs;

	// rounding add and reciprocal multiply
	assign sum  = YW'(pause) + YW'(MS_PER_SECOND - 1);
	assign prod = PW'(sum) * PW'(RECIP[MW-1:0]);
	assign quot = prod[PW-1:SHIFT];

	// clamp to the field
	assign secs = (64'(quot) > 64'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(quot);

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			item_q.granted      <= stat.granted;
			item_q.wait_seconds <= secs;
			item_q.misses_now   <= stat.misses_now;
			item_q.locked       <= stat.locked;
		end
	end

endmodule

// File: bench/tb.sv
// self-checking testbench for auth_attempt_lockout_unit: a scoreboard class predicts
// each status item; directed items come first, then random config phases
// depends on aal_pkg and the auth_attempt_lockout_unit rtl
`timescale 1ns / 100ps

module tb;
	import aal_pkg::*;

	localparam int PAUSE_BITS   = 24;
	localparam int MS_PER_S     = 1000;
	localparam int ITEMS_TARGET = 1600;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [31:0] TIMER_TOP = (32'd1 << PAUSE_BITS) - 32'd1;

	// predicts the status item for every accepted request and holds the ones still due
	class lockout_board;
		logic              guarded;
		logic [FREE_W-1:0] free_lim;
		logic [BASE_W-1:0] base_ms;
		logic [DBL_W-1:0]  dbl_max;
		logic [MISS_W-1:0] misses;
		logic [31:0]       left_ms;
		out_item_t         status_due[$];
		int                n_errors;
		int                n_checked;

		function new();
			guarded   = GUARDED_RST;
			free_lim  = FREE_MISSES_RST;
			base_ms   = BASE_PAUSE_RST;
			dbl_max   = MAX_DBL_RST;
			misses    = '0;
			left_ms   = '0;
			n_errors  = 0;
			n_checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_GUARDED:     guarded = v[0];
				CFG_FREE_MISSES: free_lim = v[FREE_W-1:0];
				CFG_BASE_PAUSE:  base_ms = v[BASE_W-1:0];
				CFG_MAX_DBL:     dbl_max = v[DBL_W-1:0];
				default: ;
			endcase
		endfunction

		// update the lockout state for one request and queue its status
		function void predict_status(in_item_t it);
			out_item_t   r;
			logic        grant;
			int          sh;
			logic [31:0] load;
			logic [31:0] secs;
			grant = 1'b0;
			case (it.req_type)
				REQ_TICK: begin
					if (left_ms != 0)
						left_ms = left_ms - 32'd1;
				end
				REQ_ATTEMPT: begin
					if (!guarded) begin
						grant = 1'b1;
					end else if (left_ms != 0) begin
						grant = 1'b0;
					end else if (it.proof_ok) begin
						misses = '0;
						grant = 1'b1;
					end else begin
						if (misses != MISS_MAX)
							misses = misses + MISS_W'(1);
						if (misses >= free_lim) begin
							sh = int'(misses) - int'(free_lim);
							if (sh > int'(dbl_max))
								sh = int'(dbl_max);
							load = 32'(base_ms) << sh;
							if (load > TIMER_TOP)
								load = TIMER_TOP;
							left_ms = load;
						end
					end
				end
				REQ_CLEAR: begin
					misses = '0;
					left_ms = '0;
				end
				default: ;
			endcase
			// remaining pause rounded up to whole seconds
			secs = left_ms / MS_PER_S + ((left_ms % MS_PER_S) != 0 ? 1 : 0);
			if (secs > 32'(WAIT_MAX))
				secs = 32'(WAIT_MAX);
			r.granted      = grant;
			r.wait_seconds = secs[WAIT_W-1:0];
			r.misses_now   = misses;
			r.locked       = (left_ms != 0);
			status_due.push_back(r);
		endfunction

		function void check_status(out_item_t got);
			out_item_t exp_r;
			if (status_due.size() == 0) begin
				$error("status item with nothing due: %p", got);
				n_errors++;
				return;
			end
			exp_r = status_due.pop_front();
			n_checked++;
			if (got.granted !== exp_r.granted) begin
				$error("granted: expected %0d, got %0d", exp_r.granted, got.granted);
				n_errors++;
			end
			if (got.wait_seconds !== exp_r.wait_seconds) begin
				$error("wait_seconds: expected %0d, got %0d",
					exp_r.wait_seconds, got.wait_seconds);
				n_errors++;
			end
			if (got.misses_now !== exp_r.misses_now) begin
				$error("misses_now: expected %0d, got %0d", exp_r.misses_now, got.misses_now);
				n_errors++;
			end
			if (got.locked !== exp_r.locked) begin
				$error("locked: expected %0d, got %0d", exp_r.locked, got.locked);
				n_errors++;
			end
		endfunction

		function int pending();
			return status_due.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lockout_board sb;
	int n_sent = 0;
	int n_settings = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_cnt = 0;

	auth_attempt_lockout_unit #(
		.PAUSE_TIMER_BITS(PAUSE_BITS),
		.MS_PER_SECOND(MS_PER_S)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// receiver stalls in stretches of changing character
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_cnt++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ((rx_cnt % 5) < 2);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// handshakes are settled by the falling edge, so sample there
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status(out_item);
	end

	// send one request; entered and left at a rising edge
	task automatic send_req(input logic [1:0] rt, input logic ok);
		in_item_t it;
		int gap;
		it.req_type = rt;
		it.proof_ok = ok;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.predict_status(it);
		n_sent++;
	endtask

	// wait for all status items, then write every register
	task automatic set_config(input logic g, input logic [FREE_W-1:0] f,
			input logic [BASE_W-1:0] b, input logic [DBL_W-1:0] d);
		logic [CFG_DATA_W-1:0] vals[4];
		logic [CFG_IDX_W-1:0]  idxs[4];
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		idxs = '{CFG_GUARDED, CFG_FREE_MISSES, CFG_BASE_PAUSE, CFG_MAX_DBL};
		vals = '{CFG_DATA_W'(g), CFG_DATA_W'(f), CFG_DATA_W'(b), CFG_DATA_W'(d)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(idxs[i], vals[i]);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic rand_config();
		logic              g;
		logic [FREE_W-1:0] f;
		logic [BASE_W-1:0] b;
		logic [DBL_W-1:0]  d;
		int pick;
		g = ($urandom_range(0, 4) != 0);
		pick = $urandom_range(0, 5);
		f = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd1 : (pick == 2) ? 4'd15 :
			FREE_W'($urandom_range(1, 6));
		pick = $urandom_range(0, 9);
		b = (pick == 0) ? 16'd65535 : (pick == 1) ? 16'd0 : (pick < 5) ? 16'd1 :
			BASE_W'($urandom_range(2, 40));
		pick = $urandom_range(0, 3);
		d = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 : DBL_W'($urandom_range(0, 7));
		set_config(g, f, b, d);
	endtask

	// a random request of any kind, unused codes included
	task automatic noise_req();
		int r;
		logic [1:0] rt;
		r = $urandom_range(0, 19);
		rt = (r < 8) ? REQ_TICK : (r < 15) ? REQ_ATTEMPT : (r < 18) ? REQ_CLEAR : REQ_UNUSED;
		send_req(rt, 1'($urandom_range(0, 1)));
	endtask

	// guessing runs half the time: misses, then a wait, clear or early retry, then a final try
	task automatic run_phase(input int n);
		int start;
		int k;
		int pick;
		start = n_sent;
		while (n_sent - start < n) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				k = $urandom_range(1, int'(sb.free_lim) + 2);
				repeat (k) begin
					if ($urandom_range(0, 7) == 0)
						send_req(REQ_TICK, 1'($urandom_range(0, 1)));
					send_req(REQ_ATTEMPT, 1'b0);
				end
				if (sb.left_ms <= 400) begin
					while (sb.left_ms != 0) send_req(REQ_TICK, 1'($urandom_range(0, 1)));
				end else if ($urandom_range(0, 1)) begin
					send_req(REQ_CLEAR, 1'($urandom_range(0, 1)));
				end else begin
					repeat ($urandom_range(1, 3))
						send_req(REQ_ATTEMPT, 1'($urandom_range(0, 1)));
				end
				send_req(REQ_ATTEMPT, $urandom_range(0, 2) != 0);
			end else if (pick < 8) begin
				noise_req();
			end else if (pick == 8) begin
				send_req(REQ_CLEAR, 1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 10)) send_req(REQ_TICK, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unguarded: every attempt granted, other kinds report status only
		send_req(REQ_ATTEMPT, 1'b1);
		send_req(REQ_ATTEMPT, 1'b0);
		send_req(REQ_TICK, 1'b0);
		send_req(REQ_CLEAR, 1'b1);
		send_req(REQ_UNUSED, 1'b1);

		// misses below the free limit, then zero free misses with the longest pause
		set_config(1'b1, 4'd7, 16'd65535, 3'd7);
		repeat (6) send_req(REQ_ATTEMPT, 1'b0);
		set_config(1'b1, 4'd0, 16'd65535, 3'd7);
		send_req(REQ_ATTEMPT, 1'b0);
		send_req(REQ_ATTEMPT, 1'b1);
		send_req(REQ_ATTEMPT, 1'b0);
		send_req(REQ_TICK, 1'b1);
		send_req(REQ_CLEAR, 1'b0);
		send_req(REQ_ATTEMPT, 1'b0);
		send_req(REQ_UNUSED, 1'b0);
		send_req(REQ_CLEAR, 1'b0);
		send_req(REQ_ATTEMPT, 1'b1);

		// zero base pause never locks, so the miss count can saturate
		set_config(1'b1, 4'd15, 16'd0, 3'd7);
		repeat (270) send_req(REQ_ATTEMPT, 1'b0);
		send_req(REQ_TICK, 1'b0);
		send_req(REQ_ATTEMPT, 1'b1);

		// random phases
		while (n_sent < ITEMS_TARGET) begin
			rand_config();
			run_phase($urandom_range(80, 250));
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d requests over %0d register settings, checked %0d status items",
			n_sent, n_settings, sb.n_checked);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("[auth_attempt_lockout_unit] OK");
		else
			$display("[auth_attempt_lockout_unit] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("[auth_attempt_lockout_unit] ERROR");
		$finish;
	end

endmodule
